[rtl/wmdu_pkg.sv]
// Shared types and constants for the wide multiply/divide unit.
package wmdu_pkg;

    localparam int WORD_W = 64;
    localparam int STEP_W = 6;

    localparam logic [1:0] REQ_MULU = 2'd0;
    localparam logic [1:0] REQ_MULS = 2'd1;
    localparam logic [1:0] REQ_DIVU = 2'd2;
    localparam logic [1:0] REQ_DIVS = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NEG_B,
        ST_NEG_LO,
        ST_NEG_HI,
        ST_CHECK,
        ST_ITER,
        ST_FIX_LO,
        ST_FIX_HI,
        ST_DONE
    } state_t;

    typedef struct packed {
        state_t state;
    } ctrl_t;

    typedef struct packed {
        logic check_fail;
        logic fix_fail;
    } status_t;

endpackage

[rtl/wmdu_addsub.sv]
// Shared 64-bit adder with carry in and carry out, used by every step.
module wmdu_addsub (
    input  logic [wmdu_pkg::WORD_W-1:0] x,
    input  logic [wmdu_pkg::WORD_W-1:0] y,
    input  logic                        cin,
    output logic [wmdu_pkg::WORD_W:0]   sum
);

    assign sum = {1'b0, x} + {1'b0, y} + {{wmdu_pkg::WORD_W{1'b0}}, cin};

endmodule

[rtl/wmdu_seq.sv]
// Sequencer that steps a request through sign fixing, a divide check, iteration and result fixing.
module wmdu_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  wmdu_pkg::status_t   status,
    output wmdu_pkg::ctrl_t     ctrl
);

    wmdu_pkg::state_t                 state_reg;
    wmdu_pkg::state_t                 state_next;
    logic [wmdu_pkg::STEP_W-1:0]      step_reg;
    logic [wmdu_pkg::STEP_W-1:0]      step_next;
    logic                             last_step;

    assign last_step = &step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmdu_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wmdu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = wmdu_pkg::ST_NEG_B;
                end
            end
            wmdu_pkg::ST_NEG_B:  state_next = wmdu_pkg::ST_NEG_LO;
            wmdu_pkg::ST_NEG_LO: state_next = wmdu_pkg::ST_NEG_HI;
            wmdu_pkg::ST_NEG_HI: state_next = wmdu_pkg::ST_CHECK;
            wmdu_pkg::ST_CHECK:
            begin
                state_next = status.check_fail ? wmdu_pkg::ST_DONE : wmdu_pkg::ST_ITER;
            end
            wmdu_pkg::ST_ITER:
            begin
                if (last_step)
                begin
                    state_next = wmdu_pkg::ST_FIX_LO;
                end
            end
            wmdu_pkg::ST_FIX_LO:
            begin
                state_next = status.fix_fail ? wmdu_pkg::ST_DONE : wmdu_pkg::ST_FIX_HI;
            end
            wmdu_pkg::ST_FIX_HI: state_next = wmdu_pkg::ST_DONE;
            wmdu_pkg::ST_DONE:   state_next = wmdu_pkg::ST_IDLE;
            default:             state_next = wmdu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        step_next  = (state_reg == wmdu_pkg::ST_ITER) ? step_reg + 1'b1 : '0;
        ctrl.state = state_reg;
    end

endmodule

[rtl/wide_multiply_divide_unit_core.sv]
// Top level of the wide multiply/divide unit: operand registers and shared-adder datapath.
// A divide fault at the check or a signed overflow in result fixing skips to done.
// Requests do not overlap; the 64-step shift loop runs on the single shared adder.
// Busy stays high from the accepting edge until the cycle after the done strobe.
// Done is high for one cycle; result registers hold until the next accept; no stall.
// Reset is asynchronous and active low and returns the sequencer to idle.
module wide_multiply_divide_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [1:0]  req_type,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic [63:0] dividend_high,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    output logic        divide_error
);

    wmdu_pkg::ctrl_t   ctrl;
    wmdu_pkg::status_t status;

    logic [1:0]                     op_reg;
    logic [wmdu_pkg::WORD_W-1:0]    acc_reg;
    logic [wmdu_pkg::WORD_W-1:0]    lo_reg;
    logic [wmdu_pkg::WORD_W-1:0]    div_reg;
    logic                           sa_reg;
    logic                           sb_reg;
    logic                           carry_reg;
    logic                           err_reg;

    logic [wmdu_pkg::WORD_W-1:0]    add_x;
    logic [wmdu_pkg::WORD_W-1:0]    add_y;
    logic                           add_cin;
    logic [wmdu_pkg::WORD_W:0]      sum;
    logic [wmdu_pkg::WORD_W-1:0]    shifted;
    logic                           is_div;
    logic                           neg_res;
    logic                           quot_bit;
    logic                           accept;

    assign accept   = start && (ctrl.state == wmdu_pkg::ST_IDLE);
    assign busy     = (ctrl.state != wmdu_pkg::ST_IDLE);
    assign done     = (ctrl.state == wmdu_pkg::ST_DONE);
    assign is_div   = (op_reg == wmdu_pkg::REQ_DIVU) || (op_reg == wmdu_pkg::REQ_DIVS);
    assign neg_res  = sa_reg ^ sb_reg;
    assign shifted  = {acc_reg[wmdu_pkg::WORD_W-2:0], lo_reg[wmdu_pkg::WORD_W-1]};
    assign quot_bit = acc_reg[wmdu_pkg::WORD_W-1] | sum[wmdu_pkg::WORD_W];

    assign status.check_fail = is_div && ((div_reg == '0) || sum[wmdu_pkg::WORD_W]);
    assign status.fix_fail   = (op_reg == wmdu_pkg::REQ_DIVS) &&
                               (neg_res ? (lo_reg[wmdu_pkg::WORD_W-1] &&
                                           (lo_reg[wmdu_pkg::WORD_W-2:0] != '0))
                                        : lo_reg[wmdu_pkg::WORD_W-1]);

    assign result_low   = lo_reg;
    assign result_high  = acc_reg;
    assign divide_error = err_reg;

    wmdu_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl)
    );

    wmdu_addsub u_addsub (
        .x   (add_x),
        .y   (add_y),
        .cin (add_cin),
        .sum (sum)
    );

    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        unique case (ctrl.state)
            wmdu_pkg::ST_NEG_B:
            begin
                add_x   = ~div_reg;
                add_cin = 1'b1;
            end
            wmdu_pkg::ST_NEG_LO, wmdu_pkg::ST_FIX_LO:
            begin
                add_x   = ~lo_reg;
                add_cin = 1'b1;
            end
            wmdu_pkg::ST_NEG_HI:
            begin
                add_x   = ~acc_reg;
                add_cin = carry_reg;
            end
            wmdu_pkg::ST_CHECK:
            begin
                add_x   = acc_reg;
                add_y   = ~div_reg;
                add_cin = 1'b1;
            end
            wmdu_pkg::ST_ITER:
            begin
                if (is_div)
                begin
                    add_x   = shifted;
                    add_y   = ~div_reg;
                    add_cin = 1'b1;
                end
                else
                begin
                    add_x = acc_reg;
                    add_y = lo_reg[0] ? div_reg : '0;
                end
            end
            wmdu_pkg::ST_FIX_HI:
            begin
                add_x   = ~acc_reg;
                add_cin = is_div ? 1'b1 : carry_reg;
            end
            default:
            begin
                add_x   = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.state)
            wmdu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_reg  <= req_type;
                    lo_reg  <= operand_a;
                    div_reg <= operand_b;
                    acc_reg <= dividend_high;
                    err_reg <= 1'b0;
                    unique case (req_type)
                        wmdu_pkg::REQ_MULS:
                        begin
                            sa_reg <= operand_a[wmdu_pkg::WORD_W-1];
                            sb_reg <= operand_b[wmdu_pkg::WORD_W-1];
                        end
                        wmdu_pkg::REQ_DIVS:
                        begin
                            sa_reg <= dividend_high[wmdu_pkg::WORD_W-1];
                            sb_reg <= operand_b[wmdu_pkg::WORD_W-1];
                        end
                        default:
                        begin
                            sa_reg <= 1'b0;
                            sb_reg <= 1'b0;
                        end
                    endcase
                end
            end
            wmdu_pkg::ST_NEG_B:
            begin
                if (sb_reg)
                begin
                    div_reg <= sum[wmdu_pkg::WORD_W-1:0];
                end
            end
            wmdu_pkg::ST_NEG_LO:
            begin
                carry_reg <= sum[wmdu_pkg::WORD_W];
                if (sa_reg)
                begin
                    lo_reg <= sum[wmdu_pkg::WORD_W-1:0];
                end
            end
            wmdu_pkg::ST_NEG_HI:
            begin
                if (!is_div)
                begin
                    acc_reg <= '0;
                end
                else if (sa_reg)
                begin
                    acc_reg <= sum[wmdu_pkg::WORD_W-1:0];
                end
            end
            wmdu_pkg::ST_CHECK:
            begin
                if (status.check_fail)
                begin
                    acc_reg <= '0;
                    lo_reg  <= '0;
                    err_reg <= 1'b1;
                end
            end
            wmdu_pkg::ST_ITER:
            begin
                if (is_div)
                begin
                    acc_reg <= quot_bit ? sum[wmdu_pkg::WORD_W-1:0] : shifted;
                    lo_reg  <= {lo_reg[wmdu_pkg::WORD_W-2:0], quot_bit};
                end
                else
                begin
                    acc_reg <= sum[wmdu_pkg::WORD_W:1];
                    lo_reg  <= {sum[0], lo_reg[wmdu_pkg::WORD_W-1:1]};
                end
            end
            wmdu_pkg::ST_FIX_LO:
            begin
                carry_reg <= sum[wmdu_pkg::WORD_W];
                if (status.fix_fail)
                begin
                    acc_reg <= '0;
                    lo_reg  <= '0;
                    err_reg <= 1'b1;
                end
                else if (neg_res)
                begin
                    lo_reg <= sum[wmdu_pkg::WORD_W-1:0];
                end
            end
            wmdu_pkg::ST_FIX_HI:
            begin
                if ((op_reg == wmdu_pkg::REQ_MULS && neg_res) ||
                    (op_reg == wmdu_pkg::REQ_DIVS && sa_reg))
                begin
                    acc_reg <= sum[wmdu_pkg::WORD_W-1:0];
                end
            end
            default:
            begin
                err_reg <= err_reg;
            end
        endcase
    end

endmodule

[rtl/wmdu_checker.sv]
// Port-level checker for the wide multiply/divide unit and its bind.
module wmdu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [63:0] result_low,
    input logic [63:0] result_high,
    input logic        divide_error
);

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("Result strobe seen while the unit is idle.");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not make the unit busy.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("Result strobe did not end with a return to idle.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_error) |-> (result_low == 64'd0 && result_high == 64'd0))
        else $error("Faulted divide returned a nonzero result.");

endmodule

bind wide_multiply_divide_unit_core wmdu_checker u_wmdu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .result_low   (result_low),
    .result_high  (result_high),
    .divide_error (divide_error)
);
